>>> rtl/slist_pkg.sv
// Shared command codes and control types for the sorted list insert block.
package slist_pkg;

    typedef logic cmd_t;

    localparam cmd_t CMD_INSERT = 1'b0;
    localparam cmd_t CMD_CLEAR  = 1'b1;

    // Flags that travel with one result from the sequencer to the output stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic dropped;
    } res_flags_t;

endpackage

>>> rtl/slist_mem.sv
// Single-port-write, single-port-read value store with a registered read.
module slist_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/slist_ctrl.sv
// Sequencer that walks the store once per insert, shifting entries and streaming results.
module slist_ctrl #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  slist_pkg::cmd_t               cmd,
    input  logic signed [VALUE_WIDTH-1:0] key,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic [VALUE_WIDTH-1:0]        mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  logic [VALUE_WIDTH-1:0]        mem_rdata,
    input  logic                          res_take,
    output slist_pkg::res_flags_t         res_flags,
    output logic [VALUE_WIDTH-1:0]        res_value
);
    import slist_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PROC = 1'b1;

    logic                   state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   full_reg, full_next;
    logic                   inserted_reg, inserted_next;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] carry_reg;

    logic                   accept;
    logic                   step;
    logic                   at_end;
    logic                   place;
    logic [AW-1:0]          last_idx;
    logic [VALUE_WIDTH-1:0] new_val;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign step     = (state_reg == ST_PROC) && res_take;
    assign last_idx = full_reg ? AW'(DEPTH - 1) : count_reg[AW-1:0];
    assign at_end   = (idx_reg == last_idx);

    // The key lands at the first entry not below it, or just past the old end.
    assign place = !full_reg && !inserted_reg &&
                   ((CW'(idx_reg) == count_reg) ||
                    ($signed(mem_rdata) >= $signed(key_reg)));

    // Once the key is placed, every later slot takes the entry that stood before it.
    assign new_val = place ? key_reg : (inserted_reg ? carry_reg : mem_rdata);

    assign mem_we    = step && !full_reg;
    assign mem_waddr = idx_reg;
    assign mem_wdata = new_val;
    assign mem_raddr = (state_reg == ST_PROC) ? AW'(idx_reg + AW'(1)) : '0;

    assign res_flags.valid   = (state_reg == ST_PROC);
    assign res_flags.last    = at_end;
    assign res_flags.dropped = full_reg;
    assign res_value         = new_val;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        full_next     = full_reg;
        inserted_next = inserted_reg;
        mem_re        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        full_next     = (count_reg == CW'(DEPTH));
                        idx_next      = '0;
                        inserted_next = 1'b0;
                        mem_re        = 1'b1;
                        state_next    = ST_PROC;
                    end
                end
            end
            ST_PROC:
            begin
                if (step)
                begin
                    inserted_next = inserted_reg || place;
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                        if (!full_reg)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        mem_re   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            full_reg     <= 1'b0;
            inserted_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            full_reg     <= full_next;
            inserted_reg <= inserted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key;
        end
        if (step)
        begin
            carry_reg <= mem_rdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the store depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROC) |-> (idx_reg <= last_idx))
        else $error("walk index ran past the end of the list");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_PROC) && !full_reg))
        else $error("store written outside an insert walk or while full");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear transaction did not empty the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (step && at_end && !full_reg) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("completed insert did not grow the list by one");

endmodule

>>> rtl/sorted_list_insert.sv
// Sorted list insert: top level with value store, sequencer and output register.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid, in_stall   cmd, key
//  out      output     out_valid, out_stall value, is_last, dropped
//
// An insert into a list of n entries walks n + 1 slots (a full list: DEPTH), one entry per
// cycle while the output is not stalled, through the single read port of the store; no new
// transaction is taken until the walk has ended. A clear is taken while idle and empties the list.
// Reset empties the list; the store contents are not cleared.
// A stall on the output freezes the walk; results wait in the output register.
module sorted_list_insert #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  slist_pkg::cmd_t               cmd,
    input  logic signed [VALUE_WIDTH-1:0] key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                          is_last,
    output logic                          dropped
);
    import slist_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic                   res_take;
    res_flags_t             res_flags;
    logic [VALUE_WIDTH-1:0] res_value;

    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   is_last_reg;
    logic                   dropped_reg;

    slist_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    slist_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_take  (res_take),
        .res_flags (res_flags),
        .res_value (res_value)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_flags.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_flags.valid)
        begin
            value_reg   <= res_value;
            is_last_reg <= res_flags.last;
            dropped_reg <= res_flags.dropped;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign is_last   = is_last_reg;
    assign dropped   = dropped_reg;

endmodule

>>> bench/tb.sv
// Self-checking testbench for the sorted list insert block.
`timescale 1ns / 100ps

module tb;
    import slist_pkg::*;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic signed [VALUE_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          is_last;
        logic                          dropped;
    } list_entry_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    cmd_t                          cmd       = CMD_INSERT;
    logic signed [VALUE_WIDTH-1:0] key       = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          is_last;
    logic                          dropped;

    // Model of the list as the block should hold it.
    logic signed [VALUE_WIDTH-1:0] model_values [DEPTH];
    int                            model_count = 0;

    list_entry_t expected_list_values [$];
    list_entry_t oldest;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;
    bit          idling_on      = 1'b1;

    sorted_list_insert #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .is_last   (is_last),
        .dropped   (dropped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Updates the list model for one accepted command and queues the values
    // that the block must emit for it.
    function void predict_list_emission(cmd_t op, logic signed [VALUE_WIDTH-1:0] new_key);
        int          pos;
        logic        full;
        list_entry_t entry;
        if (op == CMD_CLEAR)
        begin
            model_count = 0;
            return;
        end
        full = (model_count >= DEPTH);
        if (!full)
        begin
            pos = model_count;
            for (int i = 0; i < model_count; i++)
            begin
                if (model_values[i] >= new_key)
                begin
                    pos = i;
                    break;
                end
            end
            for (int i = model_count; i > pos; i--)
                model_values[i] = model_values[i-1];
            model_values[pos] = new_key;
            model_count++;
        end
        for (int i = 0; i < model_count; i++)
        begin
            entry.value   = model_values[i];
            entry.is_last = (i == model_count - 1);
            entry.dropped = full;
            expected_list_values.insert(expected_list_values.size(), entry);
        end
    endfunction

    function logic signed [VALUE_WIDTH-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       pick_key = KEY_MIN + $urandom_range(0, 2);
            1:       pick_key = KEY_MAX - $urandom_range(0, 2);
            2:       pick_key = $urandom_range(0, 8) - 4;
            default: pick_key = $urandom;
        endcase
    endfunction

    // Sends one transaction, with an optional idle burst first, and predicts
    // its results once the block takes it.
    task issue_command(cmd_t op, logic signed [VALUE_WIDTH-1:0] new_key);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= new_key;
        do
            @(posedge clk);
        while (in_stall);
        predict_list_emission(op, new_key);
        items_sent++;
    endtask

    // Drops valid so the last transaction is not taken again, then waits
    // until every expected result has come out.
    task wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_list_values.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_list_values.size() == 0)
            begin
                $error("unexpected result: value %0d is_last %0b dropped %0b",
                       value, is_last, dropped);
                mismatch_count++;
            end
            else
            begin
                oldest = expected_list_values.pop_front();
                if (value !== oldest.value)
                begin
                    $error("value: expected %0d, actual %0d", oldest.value, value);
                    mismatch_count++;
                end
                if (is_last !== oldest.is_last)
                begin
                    $error("is_last: expected %0b, actual %0b", oldest.is_last, is_last);
                    mismatch_count++;
                end
                if (dropped !== oldest.dropped)
                begin
                    $error("dropped: expected %0b, actual %0b", oldest.dropped, dropped);
                    mismatch_count++;
                end
            end
        end
        if (stall_left == 0 && idling_on && rst_n && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Empty list, extremes of the key, and ties at the head, middle and tail.
    task test_basic_inserts();
        issue_command(CMD_CLEAR, KEY_MAX);
        issue_command(CMD_INSERT, 0);
        issue_command(CMD_INSERT, KEY_MAX);
        issue_command(CMD_INSERT, KEY_MIN);
        issue_command(CMD_INSERT, 0);
        issue_command(CMD_INSERT, -1);
        issue_command(CMD_INSERT, 1);
        issue_command(CMD_INSERT, KEY_MAX);
        issue_command(CMD_INSERT, KEY_MIN);
        issue_command(CMD_CLEAR, 0);
        issue_command(CMD_INSERT, -1);
    endtask

    // Fill the list, then insert into a full list so the key is dropped.
    task test_full_list();
        issue_command(CMD_CLEAR, 0);
        for (int i = 0; i < DEPTH; i++)
            issue_command(CMD_INSERT, pick_key());
        issue_command(CMD_INSERT, KEY_MIN);
        issue_command(CMD_INSERT, KEY_MAX);
        issue_command(CMD_INSERT, 0);
        // Hold off until the full list has been read out completely.
        wait_for_drain();
        issue_command(CMD_CLEAR, KEY_MIN);
        issue_command(CMD_INSERT, KEY_MIN);
    endtask

    // Runs of inserts after a clear, of random length so that many reach a
    // full list, with a stray clear now and then.
    task test_random_sequences(int item_target);
        int  run_length;
        bit  paused;
        paused = 1'b0;
        while (items_sent < item_target)
        begin
            issue_command(CMD_CLEAR, pick_key());
            run_length = $urandom_range(1, DEPTH + 4);
            for (int i = 0; i < run_length; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    issue_command(CMD_CLEAR, pick_key());
                else
                    issue_command(CMD_INSERT, pick_key());
            end
            if (!paused && items_sent > item_target / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
        end
    endtask

    task test_back_to_back(int item_count);
        idling_on = 1'b0;
        issue_command(CMD_CLEAR, 0);
        for (int i = 0; i < item_count; i++)
            issue_command($urandom_range(0, 15) == 0 ? CMD_CLEAR : CMD_INSERT, pick_key());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_inserts();
        test_full_list();
        test_random_sequences(220);
        test_back_to_back(40);

        wait_for_drain();
        repeat (DEPTH + 4) @(posedge clk);

        if (mismatch_count == 0 && expected_list_values.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
